@@ sv/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define MDPP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define MDPP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/mdpp_pkg.sv @@
// shared types and constants of the disparity point projector
package mdpp_pkg;

  localparam int unsigned BF_W   = 32;
  localparam int unsigned DISP_W = 16;
  localparam int unsigned OUT_W  = 24;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FOC  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISP  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_EMIT_UNM  = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_Z_GO,
    ST_Z_RUN,
    ST_X_GO,
    ST_X_RUN,
    ST_Y_GO,
    ST_Y_RUN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    SEL_Z,
    SEL_X,
    SEL_Y
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul;
    logic     div_start;
    div_sel_e div_sel;
    logic     store;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic need_point;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

@@ sv/mdpp_div.sv @@
// iterative restoring divider, one quotient bit per cycle
module mdpp_div #(
  parameter int unsigned NUM_W = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [NUM_W-1:0]          num_i,
  input  logic [mdpp_pkg::BF_W-1:0] den_i,
  output logic [NUM_W-1:0]          quot_o,
  output logic                      done_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);
  localparam int unsigned DW = mdpp_pkg::BF_W;

  logic [NUM_W-1:0] quot_q, quot_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DW:0]      trial;
  logic [DW:0]      diff;

  always_comb begin
    trial  = {rem_q, quot_q[NUM_W-1]};
    diff   = trial - {1'b0, den_q};
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = diff[DW-1:0];
        quot_d = {quot_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[DW-1:0];
        quot_d = {quot_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

@@ sv/mdpp_datapath.sv @@
// registers, multipliers, divider and output stage of the projector
module mdpp_datapath #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mdpp_pkg::cmd_t                 cmd_i,
  output mdpp_pkg::status_t              status_o,
  input  logic                           cfg_we_i,
  input  logic [mdpp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mdpp_pkg::BF_W-1:0]      cfg_data_i,
  input  logic [COORD_BITS-1:0]          col_i,
  input  logic [COORD_BITS-1:0]          row_i,
  input  logic                           mask_i,
  input  logic [15:0]                    disparity_q4_i,
  input  logic                           disparity_valid_i,
  input  logic [7:0]                     red_i,
  input  logic [7:0]                     green_i,
  input  logic [7:0]                     blue_i,
  input  logic                           last_pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           in_filtered_o,
  output logic                           in_raw_o,
  output logic signed [23:0]             x_mm_o,
  output logic signed [23:0]             y_mm_o,
  output logic [23:0]                    z_mm_o,
  output logic [7:0]                     red_out_o,
  output logic [7:0]                     green_out_o,
  output logic [7:0]                     blue_out_o,
  output logic [23:0]                    masked_total_o,
  output logic [23:0]                    depth_total_o,
  output logic                           region_end_o
);

  localparam int unsigned P16_W = COORD_BITS + 4;
  localparam int unsigned MAG_W = (P16_W > 16) ? P16_W : 16;
  localparam int unsigned BW    = mdpp_pkg::BF_W;
  localparam int unsigned NUM_W = MAG_W + BW;
  localparam int unsigned OW    = mdpp_pkg::OUT_W;
  localparam logic [OW-1:0] SMAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] SMIN_MAG = {1'b1, {(OW-1){1'b0}}};
  localparam logic [OW-1:0] UMAX = '1;

  // configuration
  logic [15:0]   focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [15:0]   min_disp_q, max_disp_q;
  logic [BW-1:0] bf_q;
  logic          emit_q;

  // running counts
  logic [COUNT_BITS-1:0] masked_cnt_q, depth_cnt_q;
  logic [COUNT_BITS-1:0] masked_new, depth_new;

  // item
  logic [MAG_W-1:0] mag_x_q, mag_y_q;
  logic             neg_x_q, neg_y_q;
  logic [15:0]      disp_q;
  logic             filt_q, raw_q, last_q;
  logic [7:0]       red_q, green_q, blue_q;
  logic [OW-1:0]    mtot_q, dtot_q;

  // products and results
  logic [NUM_W-1:0] num_x_q, num_y_q;
  logic [BW-1:0]    den_x_q, den_y_q;
  logic [OW-1:0]    x_q, y_q, z_q;

  // output stage
  logic          out_valid_q;
  logic          filt_o_q, raw_o_q, last_o_q;
  logic [OW-1:0] x_o_q, y_o_q, z_o_q, mtot_o_q, dtot_o_q;
  logic [7:0]    red_o_q, green_o_q, blue_o_q;

  logic             in_range, kept;
  logic [P16_W-1:0] p16_x, p16_y;
  logic [MAG_W-1:0] px_e, py_e, cx_e, cy_e;
  logic [15:0]      fx_eff, fy_eff;
  logic [NUM_W-1:0] div_num, quot;
  logic [BW-1:0]    div_den;
  logic             div_done;
  logic [OW-1:0]    q_sat_s, q_sat_u;
  logic [OW-1:0]    q_clip_neg;
  logic             sel_neg;
  logic [31:0]      mtot_ext, dtot_ext;

  assign in_range = disparity_valid_i && (disparity_q4_i >= min_disp_q)
                    && (disparity_q4_i <= max_disp_q);
  assign kept = in_range && (disparity_q4_i != '0);

  assign masked_new = (mask_i && (masked_cnt_q != '1)) ? masked_cnt_q + 1'b1 : masked_cnt_q;
  assign depth_new  = (mask_i && in_range && (depth_cnt_q != '1)) ?
                      depth_cnt_q + 1'b1 : depth_cnt_q;
  assign mtot_ext = 32'(masked_new);
  assign dtot_ext = 32'(depth_new);

  assign p16_x = {col_i, 4'b0000};
  assign p16_y = {row_i, 4'b0000};
  assign px_e  = MAG_W'(p16_x);
  assign py_e  = MAG_W'(p16_y);
  assign cx_e  = MAG_W'(center_x_q);
  assign cy_e  = MAG_W'(center_y_q);
  assign fx_eff = (focal_x_q == '0) ? 16'd1 : focal_x_q;
  assign fy_eff = (focal_y_q == '0) ? 16'd1 : focal_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q    <= 16'd256;
      focal_y_q    <= 16'd256;
      center_x_q   <= '0;
      center_y_q   <= '0;
      bf_q         <= '0;
      min_disp_q   <= '0;
      max_disp_q   <= 16'hFFFF;
      emit_q       <= 1'b0;
      masked_cnt_q <= '0;
      depth_cnt_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mdpp_pkg::CFG_FOCAL_X:  focal_x_q  <= cfg_data_i[15:0];
          mdpp_pkg::CFG_FOCAL_Y:  focal_y_q  <= cfg_data_i[15:0];
          mdpp_pkg::CFG_CENTER_X: center_x_q <= cfg_data_i[15:0];
          mdpp_pkg::CFG_CENTER_Y: center_y_q <= cfg_data_i[15:0];
          mdpp_pkg::CFG_BASE_FOC: bf_q       <= cfg_data_i;
          mdpp_pkg::CFG_MIN_DISP: min_disp_q <= cfg_data_i[15:0];
          mdpp_pkg::CFG_MAX_DISP: max_disp_q <= cfg_data_i[15:0];
          mdpp_pkg::CFG_EMIT_UNM: emit_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        masked_cnt_q <= last_pixel_i ? '0 : masked_new;
        depth_cnt_q  <= last_pixel_i ? '0 : depth_new;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_x_q <= px_e < cx_e;
      neg_y_q <= py_e < cy_e;
      mag_x_q <= (px_e >= cx_e) ? px_e - cx_e : cx_e - px_e;
      mag_y_q <= (py_e >= cy_e) ? py_e - cy_e : cy_e - py_e;
      disp_q  <= disparity_q4_i;
      filt_q  <= kept && mask_i;
      raw_q   <= kept && emit_q;
      last_q  <= last_pixel_i;
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      mtot_q  <= mtot_ext[OW-1:0];
      dtot_q  <= dtot_ext[OW-1:0];
    end
    if (cmd_i.mul) begin
      num_x_q <= NUM_W'(mag_x_q) * NUM_W'(bf_q);
      num_y_q <= NUM_W'(mag_y_q) * NUM_W'(bf_q);
      den_x_q <= BW'(fx_eff) * BW'(disp_q);
      den_y_q <= BW'(fy_eff) * BW'(disp_q);
    end
  end

  always_comb begin
    case (cmd_i.div_sel)
      mdpp_pkg::SEL_X: begin
        div_num = num_x_q;
        div_den = den_x_q;
        sel_neg = neg_x_q;
      end
      mdpp_pkg::SEL_Y: begin
        div_num = num_y_q;
        div_den = den_y_q;
        sel_neg = neg_y_q;
      end
      default: begin
        div_num = NUM_W'(bf_q);
        div_den = BW'(disp_q);
        sel_neg = 1'b0;
      end
    endcase
  end

  mdpp_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (quot),
    .done_o  (div_done)
  );

  // saturation of the quotient
  always_comb begin
    q_sat_u    = (quot > NUM_W'(UMAX)) ? UMAX : quot[OW-1:0];
    q_clip_neg = (quot > NUM_W'(SMIN_MAG)) ? SMIN_MAG : quot[OW-1:0];
    if (sel_neg) begin
      q_sat_s = ~q_clip_neg + 1'b1;
    end else begin
      q_sat_s = (quot > NUM_W'(SMAX)) ? SMAX : quot[OW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      case (cmd_i.div_sel)
        mdpp_pkg::SEL_X: x_q <= q_sat_s;
        mdpp_pkg::SEL_Y: y_q <= q_sat_s;
        default:         z_q <= q_sat_u;
      endcase
    end
    if (cmd_i.out_load) begin
      filt_o_q  <= filt_q;
      raw_o_q   <= raw_q;
      last_o_q  <= last_q;
      mtot_o_q  <= mtot_q;
      dtot_o_q  <= dtot_q;
      if (filt_q || raw_q) begin
        x_o_q     <= x_q;
        y_o_q     <= y_q;
        z_o_q     <= z_q;
        red_o_q   <= red_q;
        green_o_q <= green_q;
        blue_o_q  <= blue_q;
      end else begin
        x_o_q     <= '0;
        y_o_q     <= '0;
        z_o_q     <= '0;
        red_o_q   <= '0;
        green_o_q <= '0;
        blue_o_q  <= '0;
      end
    end
  end

  assign status_o.need_point = kept && (mask_i || emit_q);
  assign status_o.div_done   = div_done;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign in_filtered_o  = filt_o_q;
  assign in_raw_o       = raw_o_q;
  assign x_mm_o         = x_o_q;
  assign y_mm_o         = y_o_q;
  assign z_mm_o         = z_o_q;
  assign red_out_o      = red_o_q;
  assign green_out_o    = green_o_q;
  assign blue_out_o     = blue_o_q;
  assign masked_total_o = mtot_o_q;
  assign depth_total_o  = dtot_o_q;
  assign region_end_o   = last_o_q;

endmodule

@@ sv/mdpp_ctrl.sv @@
// sequencing state machine of the projector
module mdpp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mdpp_pkg::status_t status_i,
  output mdpp_pkg::cmd_t    cmd_o
);

  mdpp_pkg::state_e state_q, state_d;
  logic             accept;

  assign accept = in_valid_i && (state_q == mdpp_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      mdpp_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = status_i.need_point ? mdpp_pkg::ST_MUL : mdpp_pkg::ST_DONE;
        end
      end
      mdpp_pkg::ST_MUL:   state_d = mdpp_pkg::ST_Z_GO;
      mdpp_pkg::ST_Z_GO:  state_d = mdpp_pkg::ST_Z_RUN;
      mdpp_pkg::ST_Z_RUN: if (status_i.div_done) state_d = mdpp_pkg::ST_X_GO;
      mdpp_pkg::ST_X_GO:  state_d = mdpp_pkg::ST_X_RUN;
      mdpp_pkg::ST_X_RUN: if (status_i.div_done) state_d = mdpp_pkg::ST_Y_GO;
      mdpp_pkg::ST_Y_GO:  state_d = mdpp_pkg::ST_Y_RUN;
      mdpp_pkg::ST_Y_RUN: if (status_i.div_done) state_d = mdpp_pkg::ST_DONE;
      mdpp_pkg::ST_DONE:  if (status_i.out_free) state_d = mdpp_pkg::ST_IDLE;
      default:            state_d = mdpp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = mdpp_pkg::SEL_Z;
    in_stall_o    = 1'b1;
    case (state_q)
      mdpp_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = accept;
      end
      mdpp_pkg::ST_MUL: cmd_o.mul = 1'b1;
      mdpp_pkg::ST_Z_GO: cmd_o.div_start = 1'b1;
      mdpp_pkg::ST_Z_RUN: cmd_o.store = status_i.div_done;
      mdpp_pkg::ST_X_GO: begin
        cmd_o.div_sel   = mdpp_pkg::SEL_X;
        cmd_o.div_start = 1'b1;
      end
      mdpp_pkg::ST_X_RUN: begin
        cmd_o.div_sel = mdpp_pkg::SEL_X;
        cmd_o.store   = status_i.div_done;
      end
      mdpp_pkg::ST_Y_GO: begin
        cmd_o.div_sel   = mdpp_pkg::SEL_Y;
        cmd_o.div_start = 1'b1;
      end
      mdpp_pkg::ST_Y_RUN: begin
        cmd_o.div_sel = mdpp_pkg::SEL_Y;
        cmd_o.store   = status_i.div_done;
      end
      mdpp_pkg::ST_DONE: cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mdpp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/masked_disparity_to_point_projector_unit.sv @@
// top level of the masked disparity to point projector
//
// input channel: one pixel per beat (in_valid_i / in_stall_o); output channel:
// one result per pixel (out_valid_o / out_stall_i). configuration is written
// through cfg_we_i / cfg_idx_i / cfg_data_i; the user must do so only while no
// pixel is in flight, which the block does not enforce. a pixel that yields no
// point goes from ST_IDLE to ST_DONE and reaches the output register once the
// output is free. a projected pixel runs a multiply step (ST_MUL) and then
// three divisions (z, x, y) on one shared restoring divider, one quotient bit
// per cycle with NUM_W = max(COORD_BITS+4,16)+32 steps each, before ST_DONE.
// the divider sets the rate: one pixel at a time, the next one taken the cycle
// after the result enters the output register. a result waiting under stall
// does not block the next pixel, only the hand-over of the one after it.
// reset clears the counts, loads the default register values and empties the
// output register; the running counts clear after a pixel flagged last_pixel.
module masked_disparity_to_point_projector_unit #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mdpp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mdpp_pkg::BF_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [COORD_BITS-1:0]          col_i,
  input  logic [COORD_BITS-1:0]          row_i,
  input  logic                           mask_i,
  input  logic [15:0]                    disparity_q4_i,
  input  logic                           disparity_valid_i,
  input  logic [7:0]                     red_i,
  input  logic [7:0]                     green_i,
  input  logic [7:0]                     blue_i,
  input  logic                           last_pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           in_filtered_o,
  output logic                           in_raw_o,
  output logic signed [23:0]             x_mm_o,
  output logic signed [23:0]             y_mm_o,
  output logic [23:0]                    z_mm_o,
  output logic [7:0]                     red_out_o,
  output logic [7:0]                     green_out_o,
  output logic [7:0]                     blue_out_o,
  output logic [23:0]                    masked_total_o,
  output logic [23:0]                    depth_total_o,
  output logic                           region_end_o
);

  mdpp_pkg::cmd_t    cmd;
  mdpp_pkg::status_t status;

  mdpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mdpp_datapath #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .col_i             (col_i),
    .row_i             (row_i),
    .mask_i            (mask_i),
    .disparity_q4_i    (disparity_q4_i),
    .disparity_valid_i (disparity_valid_i),
    .red_i             (red_i),
    .green_i           (green_i),
    .blue_i            (blue_i),
    .last_pixel_i      (last_pixel_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .in_filtered_o     (in_filtered_o),
    .in_raw_o          (in_raw_o),
    .x_mm_o            (x_mm_o),
    .y_mm_o            (y_mm_o),
    .z_mm_o            (z_mm_o),
    .red_out_o         (red_out_o),
    .green_out_o       (green_out_o),
    .blue_out_o        (blue_out_o),
    .masked_total_o    (masked_total_o),
    .depth_total_o     (depth_total_o),
    .region_end_o      (region_end_o)
  );

endmodule

@@ sv/mdpp_checker.sv @@
// port-level checks of the projector and their binding
`include "assert_macros.svh"

module mdpp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        in_filtered_o,
  input logic        in_raw_o,
  input logic [23:0] x_mm_o,
  input logic [23:0] y_mm_o,
  input logic [23:0] z_mm_o,
  input logic [23:0] masked_total_o,
  input logic [23:0] depth_total_o
);

  `MDPP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `MDPP_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `MDPP_ASSERT_NOW(a_no_point_zero, clk_i, rst_ni,
                   out_valid_o && !in_filtered_o && !in_raw_o,
                   x_mm_o == '0 && y_mm_o == '0 && z_mm_o == '0)
  `MDPP_ASSERT_NOW(a_depth_le_mask, clk_i, rst_ni, out_valid_o,
                   depth_total_o <= masked_total_o)

endmodule

bind masked_disparity_to_point_projector_unit mdpp_checker u_mdpp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .in_filtered_o  (in_filtered_o),
  .in_raw_o       (in_raw_o),
  .x_mm_o         (x_mm_o),
  .y_mm_o         (y_mm_o),
  .z_mm_o         (z_mm_o),
  .masked_total_o (masked_total_o),
  .depth_total_o  (depth_total_o)
);
